// ===== design/flvnalu_pkg.sv =====
package flvnalu_pkg;

   // parse phases of the tag body
   typedef enum logic [3:0] {
      PH_HDR        = 4'd0,
      PH_SKIP       = 4'd1,
      PH_SEQ_FIXED  = 4'd2,
      PH_SPS_HDR    = 4'd3,
      PH_SPS_DATA   = 4'd4,
      PH_PPS_HDR    = 4'd5,
      PH_PPS_DATA   = 4'd6,
      PH_SEQ_TAIL   = 4'd7,
      PH_LEN_PREFIX = 4'd8,
      PH_LEN_DATA   = 4'd9,
      PH_AB_SEARCH  = 4'd10,
      PH_AB_HEADER  = 4'd11,
      PH_AB_DATA    = 4'd12
   } phase_type;

   // tag status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CODEC     = 3'd1;
   localparam logic [2:0] ST_SEQ_ERR   = 3'd2;
   localparam logic [2:0] ST_LEN_ERR   = 3'd3;
   localparam logic [2:0] ST_SHORT     = 3'd4;

   // packet kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_SEQ   = 2'd1;
   localparam logic [1:0] KIND_NALU  = 2'd2;

   // exp-Golomb field selector
   localparam logic [1:0] GF_IDLE      = 2'd0;
   localparam logic [1:0] GF_FIRST_MB  = 2'd1;
   localparam logic [1:0] GF_SLICE_TYP = 2'd2;

   localparam int GOLOMB_MAX_BITS = 32;

   typedef struct packed {
      logic [5:0]  zero_count;
      logic [31:0] value;
      logic [1:0]  field;
      logic        in_suffix;
   } golomb_state_type;

endpackage

// ===== design/flvnalu_if.sv =====
interface flvnalu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       tag_last;
   modport source (output valid, data_byte, tag_last, input ready);
   modport sink (input valid, data_byte, tag_last, output ready);
endinterface

interface flvnalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  nalu_byte;
   logic        byte_valid;
   logic        nalu_first;
   logic        nalu_last;
   logic [4:0]  nalu_type;
   logic [23:0] composition_time;
   logic        tag_done;
   logic [2:0]  tag_status;
   logic [1:0]  packet_kind;
   logic [3:0]  stream_flags;
   logic [7:0]  profile;
   logic [7:0]  level;
   modport source (output valid, nalu_byte, byte_valid, nalu_first, nalu_last, nalu_type,
                   composition_time, tag_done, tag_status, packet_kind, stream_flags,
                   profile, level, input ready);
   modport sink (input valid, nalu_byte, byte_valid, nalu_first, nalu_last, nalu_type,
                 composition_time, tag_done, tag_status, packet_kind, stream_flags,
                 profile, level, output ready);
endinterface

// ===== design/flvnalu_golomb.sv =====
module flvnalu_golomb (
   input  flvnalu_pkg::golomb_state_type cur_state,
   input  logic [7:0]                    data_byte,
   output flvnalu_pkg::golomb_state_type next_state,
   output logic                          b_slice
);
   import flvnalu_pkg::*;

   // eight bit steps of the exp-Golomb decoder, MSB first
   always_comb begin
      golomb_state_type g;
      logic             bit_v;
      logic             done;
      logic [31:0]      ue;
      g = cur_state;
      ue = '0;
      b_slice = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         bit_v = data_byte[i];
         done = 1'b0;
         if (g.field != GF_IDLE) begin
            if (!g.in_suffix) begin
               if (!bit_v) begin
                  g.zero_count = g.zero_count + 6'd1;
                  if (g.zero_count >= 6'(GOLOMB_MAX_BITS)) g.field = GF_IDLE;
               end else begin
                  g.in_suffix = 1'b1;
                  g.value = 32'd1;
                  done = (g.zero_count == 6'd0);
               end
            end else begin
               g.value = {g.value[30:0], bit_v};
               g.zero_count = g.zero_count - 6'd1;
               done = (g.zero_count == 6'd0);
            end
            if (done) begin
               ue = g.value - 32'd1;
               g.in_suffix = 1'b0;
               g.value = '0;
               if (g.field == GF_FIRST_MB) begin
                  g.field = GF_SLICE_TYP;
               end else begin
                  if (ue == 32'd1 || ue == 32'd6) b_slice = 1'b1;
                  g.field = GF_IDLE;
               end
            end
         end
      end
      next_state = g;
   end

endmodule

// ===== design/flv_avc_video_tag_nalu_splitter_core.sv =====
// FLV AVC video tag splitter.
// req_ch carries one video tag body byte per transfer with tag_last on the final byte.
// rsp_ch returns exactly one result per byte: the byte when it belongs to a NALU, with
// first/last framing and NAL type, plus composition time, sticky stream flags, profile
// and level; tag_done and tag_status come on the result of the tag's last byte.
// Coded packets split by length prefixes or start codes, as csr_write_data selected.
// The user must write it via csr_write_enable while the block is idle (unchecked).
// A req transfer's result enters the output register in the cycle after it.
// One byte per cycle is taken unless rsp_ch stalls: all parse state updates on accept.
// req_ch.ready is high while the output register is empty or being taken, so a stall
// on rsp_ch holds the pending result and stops intake only while it lasts.
// A synchronous reset returns the parser to the tag header, clears sticky flags,
// held time and profile/level, sets four-byte length prefixes and empties the output.
module flv_avc_video_tag_nalu_splitter_core (
   input  logic        clock,
   input  logic        reset,
   flvnalu_req_if.sink   req_ch,
   flvnalu_rsp_if.source rsp_ch,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import flvnalu_pkg::*;

   logic             fmt_ff;
   logic [3:0]       pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [1:0]       lfs_ff, lfs_in;
   logic [31:0]      lacc_ff, lacc_in;
   logic [31:0]      brem_ff, brem_in;
   logic [1:0]       zrun_ff, zrun_in;
   golomb_state_type gol_ff, gol_in, gol_step;
   logic             gol_bslice;
   logic [3:0]       sticky_ff, sticky_in;
   logic [23:0]      time_ff, time_in;
   logic [7:0]       prof_ff, prof_in;
   logic [7:0]       lvl_ff, lvl_in;
   logic [2:0]       terr_ff, terr_in;
   logic [2:0]       hcnt_ff, hcnt_in;
   logic [4:0]       ctype_ff, ctype_in;
   logic [1:0]       kind_ff, kind_in;
   logic             atfirst_ff, atfirst_in;
   logic             found_ff, found_in;

   logic             out_valid_ff;
   logic             accept;
   logic             r_valid, r_first, r_last;
   logic [2:0]       r_status;

   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   function automatic logic [1:0] zero_next(input logic [7:0] b, input logic [1:0] zr);
      if (b != 8'd0) return 2'd0;
      return (zr >= 2'd2) ? 2'd2 : zr + 2'd1;
   endfunction

   flvnalu_golomb u_golomb (
      .cur_state  (gol_ff),
      .data_byte  (req_ch.data_byte),
      .next_state (gol_step),
      .b_slice    (gol_bslice)
   );

   // one parse step per accepted byte
   always_comb begin
      logic [7:0] b;
      logic       last_in;
      logic [2:0] end_err;
      logic       hdr;
      b = req_ch.data_byte;
      last_in = req_ch.tag_last;
      end_err = ST_OK;
      hdr = 1'b0;
      r_valid = 1'b0;
      r_first = 1'b0;
      r_last = 1'b0;
      r_status = ST_OK;
      pos_in = (pos_ff != 4'hf) ? pos_ff + 4'd1 : pos_ff;
      phase_in = phase_ff;
      lfs_in = lfs_ff;
      lacc_in = lacc_ff;
      brem_in = brem_ff;
      zrun_in = zrun_ff;
      gol_in = gol_ff;
      sticky_in = sticky_ff;
      time_in = time_ff;
      prof_in = prof_ff;
      lvl_in = lvl_ff;
      terr_in = terr_ff;
      hcnt_in = hcnt_ff;
      ctype_in = ctype_ff;
      kind_in = kind_ff;
      atfirst_in = atfirst_ff;
      found_in = found_ff;

      unique case (phase_ff)
         PH_HDR: begin
            if (pos_ff == 4'd0) begin
               if (b[3:0] != 4'd7) begin
                  terr_in = ST_CODEC;
                  phase_in = PH_SKIP;
               end else if (b[7:4] == 4'd5) begin
                  phase_in = PH_SKIP;
               end
            end else if (pos_ff == 4'd1) begin
               kind_in = (b == 8'd0) ? KIND_SEQ : (b == 8'd1) ? KIND_NALU : KIND_OTHER;
            end else begin
               time_in = {time_ff[15:0], b};
               if (pos_ff >= 4'd4) begin
                  hcnt_in = '0;
                  lacc_in = '0;
                  zrun_in = '0;
                  found_in = 1'b0;
                  if (kind_ff == KIND_SEQ) phase_in = PH_SEQ_FIXED;
                  else if (kind_ff == KIND_NALU)
                     phase_in = fmt_ff ? PH_AB_SEARCH : PH_LEN_PREFIX;
                  else phase_in = PH_SKIP;
               end
            end
         end
         PH_SEQ_FIXED: begin
            if (pos_ff == 4'd6) prof_in = b;
            else if (pos_ff == 4'd8) lvl_in = b;
            else if (pos_ff >= 4'd9) begin
               lfs_in = b[1:0];
               phase_in = PH_SPS_HDR;
               hcnt_in = '0;
            end
         end
         PH_SPS_HDR, PH_PPS_HDR: begin
            if (hcnt_ff == 3'd0) begin
               if (b[4:0] != 5'd1) begin
                  terr_in = ST_SEQ_ERR;
                  phase_in = PH_SKIP;
               end else begin
                  lacc_in = '0;
                  hcnt_in = 3'd1;
               end
            end else begin
               lacc_in = {16'd0, lacc_ff[7:0], b};
               if (hcnt_ff == 3'd1) begin
                  hcnt_in = 3'd2;
               end else begin
                  hcnt_in = '0;
                  if (lacc_in == 32'd0) begin
                     terr_in = ST_SEQ_ERR;
                     phase_in = PH_SKIP;
                  end else begin
                     brem_in = lacc_in;
                     atfirst_in = 1'b1;
                     phase_in = (phase_ff == PH_SPS_HDR) ? PH_SPS_DATA : PH_PPS_DATA;
                  end
               end
            end
         end
         PH_SPS_DATA, PH_PPS_DATA: begin
            r_valid = 1'b1;
            if (atfirst_ff) begin
               r_first = 1'b1;
               atfirst_in = 1'b0;
               ctype_in = b[4:0];
            end
            brem_in = brem_ff - 32'd1;
            if (brem_in == 32'd0) begin
               r_last = 1'b1;
               phase_in = (phase_ff == PH_SPS_DATA) ? PH_PPS_HDR : PH_SEQ_TAIL;
               hcnt_in = '0;
            end else if (last_in) r_last = 1'b1;
         end
         PH_LEN_PREFIX: begin
            lacc_in = (hcnt_ff == 3'd0) ? {24'd0, b} : {lacc_ff[23:0], b};
            hcnt_in = hcnt_ff + 3'd1;
            if (hcnt_in >= {1'b0, lfs_ff} + 3'd1) begin
               hcnt_in = '0;
               if (lacc_in != 32'd0) begin
                  brem_in = lacc_in;
                  atfirst_in = 1'b1;
                  phase_in = PH_LEN_DATA;
               end
               if (last_in) end_err = ST_LEN_ERR;
            end
         end
         PH_LEN_DATA: begin
            r_valid = 1'b1;
            if (atfirst_ff) begin
               r_first = 1'b1;
               atfirst_in = 1'b0;
               hdr = 1'b1;
            end else begin
               gol_in = gol_step;
               if (gol_bslice) sticky_in[3] = 1'b1;
            end
            brem_in = brem_ff - 32'd1;
            if (brem_in == 32'd0) begin
               r_last = 1'b1;
               phase_in = PH_LEN_PREFIX;
               hcnt_in = '0;
            end else if (last_in) begin
               r_last = 1'b1;
               end_err = ST_LEN_ERR;
            end
         end
         PH_AB_SEARCH: begin
            if (zrun_ff >= 2'd2 && b == 8'd1) begin
               zrun_in = '0;
               phase_in = PH_AB_HEADER;
            end else zrun_in = zero_next(b, zrun_ff);
         end
         PH_AB_HEADER: begin
            r_valid = 1'b1;
            r_first = 1'b1;
            found_in = 1'b1;
            hdr = 1'b1;
            zrun_in = zero_next(b, zrun_ff);
            phase_in = PH_AB_DATA;
            if (last_in) r_last = 1'b1;
         end
         PH_AB_DATA: begin
            r_valid = 1'b1;
            gol_in = gol_step;
            if (gol_bslice) sticky_in[3] = 1'b1;
            if (zrun_ff >= 2'd2 && b == 8'd1) begin
               r_last = 1'b1;
               zrun_in = '0;
               phase_in = PH_AB_HEADER;
            end else begin
               zrun_in = zero_next(b, zrun_ff);
               if (last_in) r_last = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // NAL header of a coded NALU: type flags and Golomb restart
      if (hdr) begin
         ctype_in = b[4:0];
         if (b[4:0] == 5'd5) sticky_in[0] = 1'b1;
         else if (b[4:0] == 5'd9) sticky_in[1] = 1'b1;
         else if (b[4:0] == 5'd7 || b[4:0] == 5'd8) sticky_in[2] = 1'b1;
         gol_in = '0;
         if (!sticky_in[3] && (b[4:0] == 5'd1 || b[4:0] == 5'd2 || b[4:0] == 5'd5))
            gol_in.field = GF_FIRST_MB;
      end

      if (r_last) gol_in.field = GF_IDLE;

      // end-of-tag status
      if (last_in) begin
         if (end_err != ST_OK) r_status = end_err;
         else if (terr_in != ST_OK) r_status = terr_in;
         else begin
            unique case (phase_in)
               PH_HDR: r_status = ST_SHORT;
               PH_SEQ_FIXED, PH_SPS_HDR, PH_SPS_DATA, PH_PPS_HDR, PH_PPS_DATA:
                  r_status = ST_SEQ_ERR;
               PH_LEN_PREFIX: r_status = (hcnt_in >= 3'd2) ? ST_LEN_ERR : ST_OK;
               PH_LEN_DATA: r_status = ST_LEN_ERR;
               PH_AB_SEARCH, PH_AB_HEADER, PH_AB_DATA:
                  r_status = found_in ? ST_OK : ST_LEN_ERR;
               default: r_status = ST_OK;
            endcase
         end
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= 1'b0;
         pos_ff <= '0;
         phase_ff <= PH_HDR;
         lfs_ff <= 2'd3;
         lacc_ff <= '0;
         brem_ff <= '0;
         zrun_ff <= '0;
         gol_ff <= '0;
         sticky_ff <= '0;
         time_ff <= '0;
         prof_ff <= '0;
         lvl_ff <= '0;
         terr_ff <= ST_OK;
         hcnt_ff <= '0;
         ctype_ff <= '0;
         kind_ff <= KIND_OTHER;
         atfirst_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         if (csr_write_enable) fmt_ff <= csr_write_data;
         if (accept) begin
            lfs_ff <= lfs_in;
            sticky_ff <= sticky_in;
            time_ff <= time_in;
            prof_ff <= prof_in;
            lvl_ff <= lvl_in;
            ctype_ff <= ctype_in;
            if (req_ch.tag_last) begin
               pos_ff <= '0;
               phase_ff <= PH_HDR;
               terr_ff <= ST_OK;
               kind_ff <= KIND_OTHER;
               hcnt_ff <= '0;
               brem_ff <= '0;
               lacc_ff <= '0;
               zrun_ff <= '0;
               gol_ff <= '0;
               atfirst_ff <= 1'b0;
               found_ff <= 1'b0;
            end else begin
               pos_ff <= pos_in;
               phase_ff <= phase_in;
               terr_ff <= terr_in;
               kind_ff <= kind_in;
               hcnt_ff <= hcnt_in;
               brem_ff <= brem_in;
               lacc_ff <= lacc_in;
               zrun_ff <= zrun_in;
               gol_ff <= gol_in;
               atfirst_ff <= atfirst_in;
               found_ff <= found_in;
            end
         end
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         out_valid_ff <= accept;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ch.nalu_byte <= r_valid ? req_ch.data_byte : 8'd0;
         rsp_ch.byte_valid <= r_valid;
         rsp_ch.nalu_first <= r_valid && r_first;
         rsp_ch.nalu_last <= r_valid && r_last;
         rsp_ch.nalu_type <= r_valid ? ctype_in : 5'd0;
         rsp_ch.composition_time <= time_in;
         rsp_ch.tag_done <= req_ch.tag_last;
         rsp_ch.tag_status <= r_status;
         rsp_ch.packet_kind <= kind_in;
         rsp_ch.stream_flags <= sticky_in;
         rsp_ch.profile <= prof_in;
         rsp_ch.level <= lvl_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;

endmodule

// ===== sim/tb_flv_avc_video_tag_nalu_splitter_core.sv =====
`timescale 1ns / 1ps
module tb_flv_avc_video_tag_nalu_splitter_core;
   import flvnalu_pkg::*;

   typedef struct packed {
      logic [7:0]  nalu_byte;
      logic        byte_valid;
      logic        nalu_first;
      logic        nalu_last;
      logic [4:0]  nalu_type;
      logic [23:0] composition_time;
      logic        tag_done;
      logic [2:0]  tag_status;
      logic [1:0]  packet_kind;
      logic [3:0]  stream_flags;
      logic [7:0]  profile;
      logic [7:0]  level;
   } demux_out_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic csr_write_data = 0;

   flvnalu_req_if req_ch ();
   flvnalu_rsp_if rsp_ch ();

   flv_avc_video_tag_nalu_splitter_core u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic        m_format;
   logic [23:0] m_pos;
   phase_type   m_phase;
   logic [1:0]  m_lfs;
   logic [31:0] m_acc, m_remain;
   logic [1:0]  m_zrun;
   logic [5:0]  m_gzero;
   logic [31:0] m_gval;
   logic [1:0]  m_gfield;
   logic        m_gsuffix;
   logic [3:0]  m_flags;
   logic [23:0] m_time;
   logic [15:0] m_pl;
   logic [2:0]  m_err;
   logic [2:0]  m_hcount;
   logic [4:0]  m_type;
   logic [1:0]  m_kind;
   logic        m_at_first, m_found;

   demux_out_t expected_q[$];
   int errors = 0;
   int n_sent = 0, n_checked = 0, n_tags = 0;

   task automatic demux_reset();
      m_format = 0; m_pos = 0; m_phase = PH_HDR; m_lfs = 2'd3; m_acc = 0; m_remain = 0;
      m_zrun = 0; m_gzero = 0; m_gval = 0; m_gfield = GF_IDLE; m_gsuffix = 0;
      m_flags = 0; m_time = 0; m_pl = 0; m_err = ST_OK; m_hcount = 0; m_type = 0;
      m_kind = KIND_OTHER; m_at_first = 0; m_found = 0;
   endtask

   function automatic logic [1:0] zero_after(logic [7:0] b);
      if (b != 0) return 2'd0;
      return (m_zrun >= 2) ? 2'd2 : m_zrun + 2'd1;
   endfunction

   task automatic golomb_step(logic bit_in);
      logic [31:0] ue;
      if (m_gfield == GF_IDLE) return;
      if (!m_gsuffix) begin
         if (!bit_in) begin
            m_gzero++;
            if (m_gzero >= GOLOMB_MAX_BITS) m_gfield = GF_IDLE;
            return;
         end
         m_gsuffix = 1; m_gval = 1;
      end else begin
         m_gval = {m_gval[30:0], bit_in};
         m_gzero--;
      end
      if (m_gzero == 0) begin
         ue = m_gval - 1;
         m_gsuffix = 0; m_gval = 0;
         if (m_gfield == GF_FIRST_MB) m_gfield = GF_SLICE_TYP;
         else begin
            if (ue == 1 || ue == 6) m_flags[3] = 1;
            m_gfield = GF_IDLE;
         end
      end
   endtask

   task automatic golomb_bits(logic [7:0] b);
      for (int i = 7; i >= 0; i--) golomb_step(b[i]);
   endtask

   task automatic nal_header(logic [7:0] b);
      m_type = b[4:0];
      if (m_type == 5) m_flags[0] = 1;
      else if (m_type == 9) m_flags[1] = 1;
      else if (m_type == 7 || m_type == 8) m_flags[2] = 1;
      m_gfield = GF_IDLE; m_gzero = 0; m_gval = 0; m_gsuffix = 0;
      if (!m_flags[3] && (m_type == 1 || m_type == 2 || m_type == 5))
         m_gfield = GF_FIRST_MB;
   endtask

   // works out the result for one tag byte
   task automatic demux_predict(logic [7:0] b, logic last_in);
      demux_out_t r;
      logic vld, first, lastb;
      logic [2:0] end_err, status;
      logic [23:0] pos;
      vld = 0; first = 0; lastb = 0; end_err = ST_OK; status = ST_OK;
      pos = m_pos;
      if (m_pos != 24'hffffff) m_pos++;
      case (m_phase)
         PH_HDR: begin
            if (pos == 0) begin
               if (b[3:0] != 7) begin m_err = ST_CODEC; m_phase = PH_SKIP; end
               else if (b[7:4] == 5) m_phase = PH_SKIP;
            end else if (pos == 1) begin
               m_kind = (b == 0) ? KIND_SEQ : (b == 1) ? KIND_NALU : KIND_OTHER;
            end else begin
               m_time = {m_time[15:0], b};
               if (pos >= 4) begin
                  m_hcount = 0; m_acc = 0; m_zrun = 0; m_found = 0;
                  if (m_kind == KIND_SEQ) m_phase = PH_SEQ_FIXED;
                  else if (m_kind == KIND_NALU)
                     m_phase = m_format ? PH_AB_SEARCH : PH_LEN_PREFIX;
                  else m_phase = PH_SKIP;
               end
            end
         end
         PH_SEQ_FIXED: begin
            if (pos == 6) m_pl[15:8] = b;
            else if (pos == 8) m_pl[7:0] = b;
            else if (pos >= 9) begin
               m_lfs = b[1:0]; m_phase = PH_SPS_HDR; m_hcount = 0;
            end
         end
         PH_SPS_HDR, PH_PPS_HDR: begin
            if (m_hcount == 0) begin
               if (b[4:0] != 1) begin m_err = ST_SEQ_ERR; m_phase = PH_SKIP; end
               else begin m_acc = 0; m_hcount = 1; end
            end else begin
               m_acc = {16'd0, m_acc[7:0], b};
               if (m_hcount == 1) m_hcount = 2;
               else begin
                  m_hcount = 0;
                  if (m_acc == 0) begin m_err = ST_SEQ_ERR; m_phase = PH_SKIP; end
                  else begin
                     m_remain = m_acc; m_at_first = 1;
                     m_phase = (m_phase == PH_SPS_HDR) ? PH_SPS_DATA : PH_PPS_DATA;
                  end
               end
            end
         end
         PH_SPS_DATA, PH_PPS_DATA: begin
            vld = 1;
            if (m_at_first) begin first = 1; m_at_first = 0; m_type = b[4:0]; end
            m_remain--;
            if (m_remain == 0) begin
               lastb = 1; m_hcount = 0;
               m_phase = (m_phase == PH_SPS_DATA) ? PH_PPS_HDR : PH_SEQ_TAIL;
            end else if (last_in) lastb = 1;
         end
         PH_LEN_PREFIX: begin
            m_acc = (m_hcount == 0) ? {24'd0, b} : {m_acc[23:0], b};
            m_hcount++;
            if (m_hcount >= {1'b0, m_lfs} + 3'd1) begin
               m_hcount = 0;
               if (m_acc != 0) begin
                  m_remain = m_acc; m_at_first = 1; m_phase = PH_LEN_DATA;
               end
               if (last_in) end_err = ST_LEN_ERR;
            end
         end
         PH_LEN_DATA: begin
            vld = 1;
            if (m_at_first) begin first = 1; m_at_first = 0; nal_header(b); end
            else golomb_bits(b);
            m_remain--;
            if (m_remain == 0) begin
               lastb = 1; m_phase = PH_LEN_PREFIX; m_hcount = 0;
            end else if (last_in) begin lastb = 1; end_err = ST_LEN_ERR; end
         end
         PH_AB_SEARCH: begin
            if (m_zrun >= 2 && b == 1) begin m_zrun = 0; m_phase = PH_AB_HEADER; end
            else m_zrun = zero_after(b);
         end
         PH_AB_HEADER: begin
            vld = 1; first = 1; m_found = 1;
            nal_header(b);
            m_zrun = zero_after(b);
            m_phase = PH_AB_DATA;
            if (last_in) lastb = 1;
         end
         PH_AB_DATA: begin
            vld = 1;
            golomb_bits(b);
            if (m_zrun >= 2 && b == 1) begin
               lastb = 1; m_zrun = 0; m_phase = PH_AB_HEADER;
            end else begin
               m_zrun = zero_after(b);
               if (last_in) lastb = 1;
            end
         end
         default: ;
      endcase
      if (lastb) m_gfield = GF_IDLE;
      if (last_in) begin
         if (end_err != ST_OK) status = end_err;
         else if (m_err != ST_OK) status = m_err;
         else case (m_phase)
            PH_HDR: status = ST_SHORT;
            PH_SEQ_FIXED, PH_SPS_HDR, PH_SPS_DATA, PH_PPS_HDR, PH_PPS_DATA:
               status = ST_SEQ_ERR;
            PH_LEN_PREFIX: status = (m_hcount >= 2) ? ST_LEN_ERR : ST_OK;
            PH_LEN_DATA: status = ST_LEN_ERR;
            PH_AB_SEARCH, PH_AB_HEADER, PH_AB_DATA:
               status = m_found ? ST_OK : ST_LEN_ERR;
            default: status = ST_OK;
         endcase
      end
      r.nalu_byte = vld ? b : 8'd0;
      r.byte_valid = vld;
      r.nalu_first = vld && first;
      r.nalu_last = vld && lastb;
      r.nalu_type = vld ? m_type : 5'd0;
      r.composition_time = m_time;
      r.tag_done = last_in;
      r.tag_status = status;
      r.packet_kind = m_kind;
      r.stream_flags = m_flags;
      r.profile = m_pl[15:8];
      r.level = m_pl[7:0];
      expected_q.push_back(r);
      if (last_in) begin
         m_pos = 0; m_phase = PH_HDR; m_err = ST_OK; m_kind = KIND_OTHER; m_hcount = 0;
         m_remain = 0; m_acc = 0; m_zrun = 0; m_gfield = GF_IDLE; m_gzero = 0;
         m_gval = 0; m_gsuffix = 0; m_at_first = 0; m_found = 0;
      end
   endtask

   // sends one tag byte; valid stays high into the next byte when there is no gap
   task automatic send_byte(logic [7:0] b, logic last_in);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.data_byte <= b; req_ch.tag_last <= last_in;
      do @(posedge clock); while (!req_ch.ready);
      demux_predict(b, last_in);
      n_sent++;
      if (last_in) n_tags++;
   endtask

   task automatic send_tag(logic [7:0] bytes[$]);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_format(logic fmt);
      wait_drained();
      csr_write_enable <= 1; csr_write_data <= fmt;
      @(posedge clock);
      csr_write_enable <= 0;
      m_format = fmt;
   endtask

   // result checker
   always @(posedge clock) begin
      demux_out_t got, exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.nalu_byte, rsp_ch.byte_valid, rsp_ch.nalu_first, rsp_ch.nalu_last,
                 rsp_ch.nalu_type, rsp_ch.composition_time, rsp_ch.tag_done,
                 rsp_ch.tag_status, rsp_ch.packet_kind, rsp_ch.stream_flags,
                 rsp_ch.profile, rsp_ch.level};
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $time, got);
            errors++;
         end else begin
            exp_r = expected_q.pop_front();
            n_checked++;
            if (got !== exp_r) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   initial begin
      int stall;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         rsp_ch.ready <= 1;
         @(posedge clock);
         stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] rnd_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'h01;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // random slice payload; leading bits feed the Golomb decode
   task automatic add_body(ref logic [7:0] t[$], input int n, input logic ab);
      for (int i = 0; i < n; i++) begin
         logic [7:0] v;
         v = (i == 0) ? {3'b000, 5'($urandom_range(0, 31))} | 8'($urandom_range(0, 7) << 5)
                      : rnd_byte();
         if (ab && i > 0 && v == 1 && t.size() >= 2 && t[$] == 0 && t[$ - 1] == 0) v = 8'h02;
         t.push_back(v);
      end
   endtask

   function automatic logic [7:0] pick_type();
      int k;
      k = $urandom_range(0, 9);
      if (k < 3) return 8'h65;
      if (k < 6) return 8'h41;
      if (k == 6) return 8'h09;
      if (k == 7) return 8'h67;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic build_len_tag(ref logic [7:0] t[$], input logic [1:0] lfs);
      int nn, len;
      t = {8'h17, 8'h01, rnd_byte(), rnd_byte(), rnd_byte()};
      nn = $urandom_range(1, 3);
      for (int k = 0; k < nn; k++) begin
         len = $urandom_range(0, 8);
         for (int j = lfs; j >= 0; j--) t.push_back(8'(len >> (8 * j)));
         if (len > 0) begin
            t.push_back(pick_type());
            add_body(t, len - 1, 0);
         end
      end
   endtask

   task automatic build_ab_tag(ref logic [7:0] t[$]);
      int nn;
      t = {8'h27, 8'h01, rnd_byte(), rnd_byte(), rnd_byte()};
      if ($urandom_range(0, 3) == 0) t.push_back(8'h55);
      nn = $urandom_range(1, 3);
      for (int k = 0; k < nn; k++) begin
         if ($urandom_range(0, 1)) t.push_back(8'h00);
         t.push_back(8'h00); t.push_back(8'h00); t.push_back(8'h01);
         t.push_back(pick_type());
         add_body(t, $urandom_range(0, 7), 1);
      end
   endtask

   task automatic build_seq_tag(ref logic [7:0] t[$], input logic [1:0] lfs);
      int sl, pl;
      sl = $urandom_range(1, 5); pl = $urandom_range(1, 3);
      t = {8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), {6'h3f, lfs},
           8'he1, 8'h00, 8'(sl), 8'h67};
      add_body(t, sl - 1, 0);
      t.push_back(8'h01); t.push_back(8'h00); t.push_back(8'(pl)); t.push_back(8'h68);
      add_body(t, pl - 1, 0);
   endtask

   // corrupt some tags: truncate, flip a byte
   task automatic mangle(ref logic [7:0] t[$]);
      int k;
      k = $urandom_range(0, 9);
      if (k == 0 && t.size() > 1) t = t[0:$urandom_range(0, t.size() - 2)];
      else if (k == 1) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
   endtask

   task automatic test_directed_headers();
      logic [7:0] t[$];
      t = {8'h17}; send_tag(t);                       // short tag
      t = {8'h16, 8'h01, 8'h00}; send_tag(t);         // wrong codec
      t = {8'h57, 8'h01}; send_tag(t);                // frame type 5 skipped
      t = {8'h17, 8'h02, 8'hff, 8'hff, 8'hff, 8'haa}; send_tag(t); // other packet type
      t = {8'h17, 8'h01, 8'h12, 8'h34}; send_tag(t);  // short, time partial
   endtask

   task automatic test_directed_seq_header();
      logic [7:0] t[$];
      // good header, 1-byte lengths selected
      t = {8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h28, 8'hfc,
           8'he1, 8'h00, 8'h02, 8'h67, 8'h64, 8'h01, 8'h00, 8'h01, 8'h68, 8'hff};
      send_tag(t);
      // bad SPS count, zero SPS length, truncated before PPS
      t = {8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h4d, 8'h00, 8'h1f, 8'hff,
           8'he2, 8'h00};
      send_tag(t);
      t = {8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h4d, 8'h00, 8'h1f, 8'hfe,
           8'he1, 8'h00, 8'h00, 8'h00};
      send_tag(t);
      t = {8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h42, 8'h00, 8'h0a, 8'hff,
           8'he1, 8'h00, 8'h01, 8'h67};
      send_tag(t);
   endtask

   task automatic test_directed_lengths();
      logic [7:0] t[$];
      // 4-byte prefixes: IDR with I slice (first_mb 0, slice kind 2), trailing byte
      t = {8'h17, 8'h01, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'hb8,
           8'h00, 8'h00, 8'h00, 8'h00, 8'h09};
      send_tag(t);
      // prefix complete at end; then truncated NALU
      t = {8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05};
      send_tag(t);
      t = {8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h41, 8'h00};
      send_tag(t);
      // long zero Golomb prefix
      t = {8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h41, 8'h00,
           8'h00, 8'h00, 8'h00, 8'h00};
      send_tag(t);
   endtask

   task automatic test_directed_start_codes();
      logic [7:0] t[$];
      write_format(1);
      t = {8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'haa, 8'h00, 8'h00, 8'h01, 8'h09, 8'hf0,
           8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42};
      send_tag(t);
      t = {8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01}; send_tag(t); // no header
      t = {8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65}; send_tag(t);
   endtask

   task automatic test_random(int n_items);
      logic [7:0] t[$];
      logic [1:0] lfs;
      int k;
      lfs = 2'd0;
      while (n_sent < n_items) begin
         k = $urandom_range(0, 19);
         if (k < 3) begin
            lfs = 2'($urandom_range(0, 3));
            build_seq_tag(t, lfs);
         end else if (k < 15) begin
            if (m_format) build_ab_tag(t); else build_len_tag(t, m_lfs);
         end else if (k == 15) begin
            t = {};
            repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
         end else if (k == 16) begin
            write_format(1'($urandom_range(0, 1)));
            continue;
         end else if (k == 17) begin
            wait_drained();
            continue;
         end else begin
            if (m_format) build_ab_tag(t); else build_len_tag(t, m_lfs);
         end
         mangle(t);
         send_tag(t);
      end
   endtask

   initial begin
      req_ch.valid = 0; req_ch.data_byte = 0; req_ch.tag_last = 0;
      demux_reset();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed_headers();
      test_directed_seq_header();
      test_directed_lengths();
      test_directed_start_codes();
      write_format(0);
      test_random(1150);
      write_format(1);
      write_format(0);
      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d bytes in %0d tags, %0d results checked",
               n_sent, n_tags, n_checked);
      $display("framings: length prefix 1..4 bytes, start codes, sequence headers, errors");
      if (errors == 0 && expected_q.size() == 0)
         $display("tb_flv_avc_video_tag_nalu_splitter_core: done, clean");
      else
         $display("tb_flv_avc_video_tag_nalu_splitter_core: done, errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_flv_avc_video_tag_nalu_splitter_core: done, errors");
      $finish;
   end
endmodule
